### src/order_book_ask_bid_matcher_unit_macros.svh
// Assertion macros shared by the order book matcher RTL.
`ifndef ORDER_BOOK_ASK_BID_MATCHER_UNIT_MACROS_SVH
`define ORDER_BOOK_ASK_BID_MATCHER_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define OBAM_ASSERT_IMPLY(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("order book matcher: check failed");

// Implication whose consequence is checked in the cycle after the condition.
`define OBAM_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("order book matcher: check failed");

`endif

### src/obam_pkg.sv
// Package with types, codes and defaults of the order book matcher.
`timescale 1ns / 1ps
package obam_pkg;

   localparam int BOOK_DEPTH_DEF  = 32;
   localparam int PRICE_BITS_DEF  = 32;
   localparam int MAX_RESULTS     = 31;
   localparam int RES_CNT_BITS    = 5;
   localparam int TAG_BITS        = 25;

   localparam logic [1:0] REQ_ASK   = 2'd0;
   localparam logic [1:0] REQ_BID   = 2'd1;
   localparam logic [1:0] REQ_MATCH = 2'd2;

   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_SALE    = 2'd1;
   localparam logic [1:0] KIND_NO_SALE = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] price;
      logic [31:0] amount;
      logic [7:0]  product_id;
      logic [15:0] time_slot;
   } obam_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        status;
      logic [31:0] sale_price;
      logic [31:0] sale_amount;
      logic [7:0]  sale_product;
      logic [15:0] sale_slot;
      logic        last;
   } obam_rsp_type;

   // One scanned book entry, qualified for each side.
   typedef struct packed {
      logic valid;
      logic ask_ok;
      logic bid_ok;
   } obam_beat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COPY,
      ST_SCAN,
      ST_DECIDE,
      ST_WR_A,
      ST_WR_B,
      ST_PUSH,
      ST_FINAL
   } obam_state_type;

endpackage

### src/obam_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module obam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### src/obam_best.sv
// Tracker of the best ask and best bid seen during one book scan.
`timescale 1ns / 1ps
module obam_best
   import obam_pkg::*;
#(
   parameter int BOOK_DEPTH = BOOK_DEPTH_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  obam_beat_type                 beat,
   input  logic [$clog2(BOOK_DEPTH)-1:0] idx,
   input  logic [PRICE_BITS-1:0]         price,
   input  logic [31:0]                   work,
   output logic                          ask_found,
   output logic [$clog2(BOOK_DEPTH)-1:0] ask_idx,
   output logic [PRICE_BITS-1:0]         ask_price,
   output logic [31:0]                   ask_work,
   output logic                          bid_found,
   output logic [$clog2(BOOK_DEPTH)-1:0] bid_idx,
   output logic [PRICE_BITS-1:0]         bid_price,
   output logic [31:0]                   bid_work
);
   localparam int AW = $clog2(BOOK_DEPTH);

   logic                  ask_found_ff, bid_found_ff;
   logic [AW-1:0]         ask_idx_ff, bid_idx_ff;
   logic [PRICE_BITS-1:0] ask_price_ff, bid_price_ff;
   logic [31:0]           ask_work_ff, bid_work_ff;
   logic                  take_ask, take_bid;

   // Strict compares keep the earliest loaded entry on equal prices.
   assign take_ask = beat.valid && beat.ask_ok && (!ask_found_ff || price < ask_price_ff);
   assign take_bid = beat.valid && beat.bid_ok && (!bid_found_ff || price > bid_price_ff);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         ask_found_ff <= 1'b0;
         bid_found_ff <= 1'b0;
      end else begin
         if (take_ask) begin
            ask_found_ff <= 1'b1;
         end
         if (take_bid) begin
            bid_found_ff <= 1'b1;
         end
      end
      if (take_ask) begin
         ask_idx_ff   <= idx;
         ask_price_ff <= price;
         ask_work_ff  <= work;
      end
      if (take_bid) begin
         bid_idx_ff   <= idx;
         bid_price_ff <= price;
         bid_work_ff  <= work;
      end
   end

   assign ask_found = ask_found_ff;
   assign ask_idx   = ask_idx_ff;
   assign ask_price = ask_price_ff;
   assign ask_work  = ask_work_ff;
   assign bid_found = bid_found_ff;
   assign bid_idx   = bid_idx_ff;
   assign bid_price = bid_price_ff;
   assign bid_work  = bid_work_ff;
endmodule

### src/order_book_ask_bid_matcher_unit.sv
// Top level of the order book matcher: control, book and work memories, output register.
`timescale 1ns / 1ps
// An insert request stores one ask or bid in the next free book entry and
// answers with one ack (status full when the book holds BOOK_DEPTH orders).
// A match request first copies the stored amounts into the work memory,
// then repeats a round per sale: a scan of the book memory for best ask and
// best bid at one entry a cycle, a decision state, write-back of the ask's
// and the bid's working amounts, and a state that queues the sale, which
// waits while a held sale cannot yet be passed to the output register. A
// match is bounded by 31 sales. Sales are held back by one so that the last
// one can carry last; a match with no sale returns one no-sale result.
// Request code 3 is dropped without a response. The stored book is never
// changed by a match. Results wait in an output register, so a new request
// is taken in the cycle the pending response is consumed.
`include "order_book_ask_bid_matcher_unit_macros.svh"
module order_book_ask_bid_matcher_unit
   import obam_pkg::*;
#(
   parameter int BOOK_DEPTH = BOOK_DEPTH_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  obam_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output obam_rsp_type rsp_data
);
   localparam int AW = $clog2(BOOK_DEPTH);
   localparam int CW = AW + 1;
   localparam int BW = PRICE_BITS + 32 + TAG_BITS;

   obam_state_type state_ff, state_in;

   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           rd_idx_ff, rd_idx_in;
   logic                    rv_ff;
   logic [AW-1:0]           ri_ff;
   logic [23:0]             key_ff, key_in;
   logic [RES_CNT_BITS-1:0] n_ff, n_in;
   logic                    pend_ff, pend_in;
   logic [PRICE_BITS-1:0]   pend_price_ff, pend_price_in;
   logic [31:0]             pend_qty_ff, pend_qty_in;
   logic [PRICE_BITS-1:0]   cur_price_ff, cur_price_in;
   logic [31:0]             cur_qty_ff, cur_qty_in;
   logic                    out_valid_ff, out_valid_in;
   obam_rsp_type            out_ff, out_in;

   logic                    rd_en, out_free, clear_best;
   logic                    book_we, work_we;
   logic [AW-1:0]           work_waddr;
   logic [31:0]             work_wdata;
   logic [BW-1:0]           book_wdata, book_q;
   logic [31:0]             work_q;
   logic [PRICE_BITS-1:0]   q_price;
   logic [31:0]             q_amount;
   logic                    q_side;
   logic [23:0]             q_key;
   obam_beat_type           beat;

   logic                    ask_found, bid_found;
   logic [AW-1:0]           ask_idx, bid_idx;
   logic [PRICE_BITS-1:0]   ask_price, bid_price;
   logic [31:0]             ask_work, bid_work;
   logic                    pair;
   logic [31:0]             qty;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Book entry layout: price, amount, side, product and slot.
   assign {q_price, q_amount, q_side, q_key} = book_q;
   assign book_we    = req_valid && req_ready && (req_data.req_type == REQ_ASK
                       || req_data.req_type == REQ_BID) && (count_ff < CW'(BOOK_DEPTH));
   assign book_wdata = {PRICE_BITS'(req_data.price), req_data.amount, req_data.req_type[0],
                        req_data.product_id, req_data.time_slot};

   // Issue one read a cycle while copying or scanning.
   assign rd_en = (state_ff == ST_COPY || state_ff == ST_SCAN) && (rd_idx_ff < count_ff);

   obam_ram #(.WIDTH(BW), .DEPTH(BOOK_DEPTH)) u_book_ram (
      .clock   (clock),
      .wr_en   (book_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (book_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (book_q)
   );

   obam_ram #(.WIDTH(32), .DEPTH(BOOK_DEPTH)) u_work_ram (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (work_waddr),
      .wr_data (work_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (work_q)
   );

   // Entries with no working amount left drop out of the scan.
   assign beat.valid  = rv_ff && (state_ff == ST_SCAN);
   assign beat.ask_ok = !q_side && (q_key == key_ff) && (work_q != 32'd0);
   assign beat.bid_ok = q_side && (q_key == key_ff) && (work_q != 32'd0);

   obam_best #(.BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS)) u_best (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear_best),
      .beat      (beat),
      .idx       (ri_ff),
      .price     (q_price),
      .work      (work_q),
      .ask_found (ask_found),
      .ask_idx   (ask_idx),
      .ask_price (ask_price),
      .ask_work  (ask_work),
      .bid_found (bid_found),
      .bid_idx   (bid_idx),
      .bid_price (bid_price),
      .bid_work  (bid_work)
   );

   assign pair = ask_found && bid_found && (bid_price >= ask_price);
   assign qty  = (ask_work < bid_work) ? ask_work : bid_work;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      key_in        = key_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      pend_price_in = pend_price_ff;
      pend_qty_in   = pend_qty_ff;
      cur_price_in  = cur_price_ff;
      cur_qty_in    = cur_qty_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      clear_best    = 1'b0;
      work_we       = 1'b0;
      work_waddr    = ri_ff;
      work_wdata    = q_amount;
      if (rd_en) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_data.req_type)
                  REQ_ASK, REQ_BID: begin
                     out_valid_in = 1'b1;
                     out_in       = '0;
                     out_in.kind  = KIND_ACK;
                     out_in.last  = 1'b1;
                     if (book_we) begin
                        count_in      = count_ff + CW'(1);
                        out_in.status = STATUS_OK;
                     end else begin
                        out_in.status = STATUS_FULL;
                     end
                  end
                  REQ_MATCH: begin
                     key_in    = {req_data.product_id, req_data.time_slot};
                     n_in      = '0;
                     pend_in   = 1'b0;
                     rd_idx_in = '0;
                     state_in  = ST_COPY;
                  end
                  default: begin
                     // drop unused request code
                  end
               endcase
            end
         end
         ST_COPY: begin
            work_we = rv_ff;
            if (!rd_en && !rv_ff) begin
               rd_idx_in  = '0;
               clear_best = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!rd_en && !rv_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cur_price_in = ask_price;
            cur_qty_in   = qty;
            state_in     = pair ? ST_WR_A : ST_FINAL;
         end
         ST_WR_A: begin
            work_we    = 1'b1;
            work_waddr = ask_idx;
            work_wdata = ask_work - cur_qty_ff;
            state_in   = ST_WR_B;
         end
         ST_WR_B: begin
            work_we    = 1'b1;
            work_waddr = bid_idx;
            work_wdata = bid_work - cur_qty_ff;
            state_in   = ST_PUSH;
         end
         ST_PUSH: begin
            // Release the held sale, hold the new one.
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  out_valid_in       = 1'b1;
                  out_in.kind        = KIND_SALE;
                  out_in.status      = STATUS_OK;
                  out_in.sale_price  = 32'(pend_price_ff);
                  out_in.sale_amount = pend_qty_ff;
                  out_in.sale_product = key_ff[23:16];
                  out_in.sale_slot   = key_ff[15:0];
                  out_in.last        = 1'b0;
               end
               pend_in       = 1'b1;
               pend_price_in = cur_price_ff;
               pend_qty_in   = cur_qty_ff;
               n_in          = n_ff + RES_CNT_BITS'(1);
               if (n_ff == RES_CNT_BITS'(MAX_RESULTS - 1)) begin
                  state_in = ST_FINAL;
               end else begin
                  rd_idx_in  = '0;
                  clear_best = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               out_valid_in        = 1'b1;
               out_in.status       = STATUS_OK;
               out_in.sale_product = key_ff[23:16];
               out_in.sale_slot    = key_ff[15:0];
               out_in.last         = 1'b1;
               if (pend_ff) begin
                  out_in.kind        = KIND_SALE;
                  out_in.sale_price  = 32'(pend_price_ff);
                  out_in.sale_amount = pend_qty_ff;
               end else begin
                  out_in.kind        = KIND_NO_SALE;
                  out_in.sale_price  = '0;
                  out_in.sale_amount = '0;
               end
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rv_ff        <= 1'b0;
         n_ff         <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rv_ff        <= rd_en;
         n_ff         <= n_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      ri_ff         <= rd_idx_ff[AW-1:0];
      key_ff        <= key_in;
      pend_price_ff <= pend_price_in;
      pend_qty_ff   <= pend_qty_in;
      cur_price_ff  <= cur_price_in;
      cur_qty_ff    <= cur_qty_in;
      out_ff        <= out_in;
   end

   `OBAM_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(BOOK_DEPTH))
   `OBAM_ASSERT_IMPLY(a_sale_nonzero, clock, reset,
      rsp_valid && rsp_data.kind == KIND_SALE, rsp_data.sale_amount != 32'd0)
   `OBAM_ASSERT_NEXT(a_full_ack, clock, reset,
      req_valid && req_ready && req_data.req_type == REQ_ASK && count_ff == CW'(BOOK_DEPTH),
      rsp_valid && rsp_data.status == STATUS_FULL)
   `OBAM_ASSERT_IMPLY(a_scan_pair, clock, reset,
      state_ff == ST_WR_A, ask_found && bid_found && cur_qty_ff != 32'd0)
endmodule

### verif/tb_order_book_ask_bid_matcher_unit.sv
// Testbench for the order book matcher: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
module tb_order_book_ask_bid_matcher_unit;
   import obam_pkg::*;

   localparam int DEPTH = BOOK_DEPTH_DEF;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   obam_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   obam_rsp_type rsp_data;

   order_book_ask_bid_matcher_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor copy of the book.
   logic [31:0] bk_price [DEPTH];
   logic [31:0] bk_amount [DEPTH];
   logic [24:0] bk_tag [DEPTH];
   logic [31:0] wk_amount [DEPTH];
   int          bk_count = 0;

   obam_req_type pending_reqs[$];
   obam_rsp_type expected_rsps[$];
   int  errors = 0;
   int  send_idle_pct = 7;
   int  recv_idle_pct = 59;
   bit  recv_hold = 1'b0;

   // Append one request to the stimulus queue.
   function automatic void queue_req(obam_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // Append one response to the expectation queue.
   function automatic void expect_rsp(obam_rsp_type o);
      expected_rsps.insert(expected_rsps.size(), o);
   endfunction

   // Best live order of one side for a key; lowest ask, highest bid, first loaded on ties.
   function automatic int best_order(bit side, logic [23:0] key);
      int best;
      best = -1;
      for (int i = 0; i < bk_count; i++) begin
         if (bk_tag[i][24] != side || bk_tag[i][23:0] != key || wk_amount[i] == 0)
            continue;
         if (best < 0)
            best = i;
         else if (side == 1'b0 ? bk_price[i] < bk_price[best] : bk_price[i] > bk_price[best])
            best = i;
      end
      return best;
   endfunction

   // Work out the responses for one accepted request.
   task automatic predict_book(obam_req_type r);
      obam_rsp_type o;
      logic [23:0]  key;
      logic [31:0]  qty;
      int a, b, n;
      key = {r.product_id, r.time_slot};
      o = '0;
      if (r.req_type == REQ_ASK || r.req_type == REQ_BID) begin
         o.kind = KIND_ACK;
         o.last = 1'b1;
         if (bk_count >= DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            bk_price[bk_count] = r.price;
            bk_amount[bk_count] = r.amount;
            bk_tag[bk_count] = {r.req_type[0], key};
            bk_count++;
            o.status = STATUS_OK;
         end
         expect_rsp(o);
      end else if (r.req_type == REQ_MATCH) begin
         n = 0;
         for (int i = 0; i < DEPTH; i++)
            wk_amount[i] = (i < bk_count) ? bk_amount[i] : 32'd0;
         o.sale_product = r.product_id;
         o.sale_slot = r.time_slot;
         while (n < MAX_RESULTS) begin
            a = best_order(1'b0, key);
            if (a < 0) break;
            b = best_order(1'b1, key);
            if (b < 0 || bk_price[b] < bk_price[a]) break;
            qty = wk_amount[a] < wk_amount[b] ? wk_amount[a] : wk_amount[b];
            wk_amount[a] -= qty;
            wk_amount[b] -= qty;
            o.kind = KIND_SALE;
            o.sale_price = bk_price[a];
            o.sale_amount = qty;
            o.last = 1'b0;
            expect_rsp(o);
            n++;
         end
         if (n == 0) begin
            o.kind = KIND_NO_SALE;
            o.last = 1'b1;
            expect_rsp(o);
         end else begin
            expected_rsps[$].last = 1'b1;
         end
      end
   endtask

   // Driver: hold valid and payload until accepted, then advance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && req_ready)
            predict_book(req_data);
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each accepted response against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               errors++;
            end else begin
               if (rsp_data !== expected_rsps[0]) begin
                  $display("%0t: mismatch expected %p actual %p", $time,
                           expected_rsps[0], rsp_data);
                  errors++;
               end
               void'(expected_rsps.pop_front());
            end
         end
         rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic obam_req_type make_req(logic [1:0] t, logic [31:0] p, logic [31:0] a,
                                             logic [7:0] pr, logic [15:0] s);
      obam_req_type r;
      r.req_type = t; r.price = p; r.amount = a; r.product_id = pr; r.time_slot = s;
      return r;
   endfunction

   // Random ask or bid for the given key; most prices fall on 16 levels so matches find counterparts.
   function automatic obam_req_type rand_order(logic [7:0] pr, logic [15:0] s);
      logic [31:0] p, a;
      p = ($urandom_range(9) == 0) ? $urandom : 32'h10000 + $urandom_range(15) * 32'h800;
      case ($urandom_range(9))
         0: a = 32'd0;
         1: a = $urandom;
         default: a = $urandom_range(20) << 14;
      endcase
      return make_req(2'($urandom_range(1)), p, a, pr, s);
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Long receiver hold-off while the sender keeps offering requests.
   initial begin
      wait (!reset);
      repeat (300) @(posedge clock);
      recv_hold = 1'b1;
      repeat (400) @(posedge clock);
      recv_hold = 1'b0;
   end

   initial begin
      logic [7:0]  pr;
      logic [15:0] s;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Directed: empty match, zero amounts, equal-price ties, extremes, unused code.
      queue_req(make_req(REQ_MATCH, 0, 0, 8'hFF, 16'hFFFF));
      queue_req(make_req(REQ_ASK, 32'h0001_0000, 32'd0, 8'h01, 16'h0001));
      queue_req(make_req(REQ_ASK, 32'h0001_0000, 32'h0002_0000, 8'h01, 16'h0001));
      queue_req(make_req(REQ_ASK, 32'h0001_0000, 32'h0003_0000, 8'h01, 16'h0001));
      queue_req(make_req(REQ_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h01, 16'h0001));
      queue_req(make_req(REQ_BID, 32'h0002_0000, 32'd0, 8'h01, 16'h0001));
      queue_req(make_req(REQ_MATCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h01, 16'h0001));
      queue_req(make_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
      queue_req(make_req(REQ_ASK, 32'h0, 32'h1, 8'hFF, 16'hFFFF));
      queue_req(make_req(REQ_BID, 32'h0, 32'h1, 8'hFF, 16'hFFFF));
      queue_req(make_req(REQ_MATCH, 0, 0, 8'hFF, 16'hFFFF));
      queue_req(make_req(REQ_BID, 32'h0, 32'h5, 8'h01, 16'h0001));
      queue_req(make_req(REQ_MATCH, 0, 0, 8'h01, 16'h0001));
      // Random: mostly hot-key orders with random matches; fills the book to full.
      for (int k = 0; k < 400; k++) begin
         pr = 8'($urandom_range(1));
         s = 16'($urandom_range(1));
         if ($urandom_range(19) == 0) begin
            pr = 8'($urandom); s = 16'($urandom);
         end
         case ($urandom_range(19))
            0, 1, 2, 3: queue_req(make_req(REQ_MATCH, $urandom, $urandom, pr, s));
            4: queue_req(make_req(2'd3, $urandom, $urandom, pr, s));
            default: queue_req(rand_order(pr, s));
         endcase
         if (k == 130) begin
            wait_drained();
            send_idle_pct = 59;
            recv_idle_pct = 7;
         end else if (k == 260) begin
            wait_drained();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      end
      wait_drained();
      if (errors == 0 && expected_rsps.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #8000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/obam_pkg.sv
src/obam_ram.sv
src/obam_best.sv
src/order_book_ask_bid_matcher_unit.sv
verif/tb_order_book_ask_bid_matcher_unit.sv
